@@ sv/efr_pkg.sv @@
package efr_pkg;

  // Frame store size and the widths that follow from it
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Line bytes with special meaning
  localparam logic [7:0] MARK_BYTE  = 8'h7D;
  localparam logic [7:0] HEAD_BYTE  = 8'h7B;
  localparam logic [7:0] STUFF_BYTE = 8'h82;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    EV_REFUSED        = 3'd0,
    EV_HEADER_REJECT  = 3'd1,
    EV_STORED         = 3'd2,
    EV_ESCAPE_DROPPED = 3'd3,
    EV_COMPLETE       = 3'd4,
    EV_RESTART        = 3'd5,
    EV_OVERFLOW       = 3'd6,
    EV_DONE           = 3'd7
  } event_t;

endpackage

@@ sv/escaped_frame_receiver.sv @@
// Byte-stuffed frame receiver. Takes one beat per clock (opcode push, read
// or release) while res_ready takes results, returning one result beat for
// each in the cycle after acceptance; throughput is one beat per cycle,
// set by the combinational header/escape state update and the one-write,
// one-read frame store. Frames open with 7D 7B and close with 7D 7D; 7D 82
// inside a frame drops the 82, 7D 7B restarts. While a frame is pending,
// pushes are refused until a release. A read returns the stored byte at
// read_index even past the current length; reading a position never
// written gives an undefined byte. The store needs no clearing after reset.
module escaped_frame_receiver
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] data_byte,
  input  logic [7:0] read_index,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [2:0] event_res,
  output logic [8:0] frame_length,
  output logic       frame_ready,
  output logic [7:0] read_data
);

  logic             accept;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             frame_pending, frame_pending_next;
  logic             escape_seen, escape_seen_next;
  logic [7:0]       last_byte, last_byte_next;
  event_t           ev_next;
  logic             store_we;
  logic             store_re;
  logic             rd_in_range;
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]       ram_q;
  event_t           ev_q;
  logic             rd_sel;

  assign item_ready  = !res_valid || res_ready;
  assign accept      = item_valid && item_ready;
  assign rd_in_range = 32'(read_index) < 32'(STORE_DEPTH);
  assign rd_addr     = STORE_AW'(read_index);
  assign store_re    = accept && (opcode == OP_READ) && rd_in_range;
  assign store_we    = accept && (opcode == OP_PUSH) && !frame_pending;

  // Deframer state update for one beat
  always_comb begin
    logic [CNT_W-1:0] cnt1;
    cnt1               = byte_count + CNT_W'(1);
    byte_count_next    = byte_count;
    frame_pending_next = frame_pending;
    escape_seen_next   = escape_seen;
    last_byte_next     = last_byte;
    ev_next            = EV_DONE;
    unique case (opcode)
      OP_PUSH: begin
        if (frame_pending) begin
          ev_next = EV_REFUSED;
        end else begin
          ev_next         = EV_STORED;
          byte_count_next = cnt1;
          last_byte_next  = data_byte;
          if (cnt1 == CNT_W'(1)) begin
            if (data_byte != MARK_BYTE) begin
              byte_count_next = '0;
              ev_next         = EV_HEADER_REJECT;
            end
            escape_seen_next = 1'b0;
          end else if (cnt1 == CNT_W'(2)) begin
            if (data_byte != HEAD_BYTE) begin
              byte_count_next = '0;
              ev_next         = EV_HEADER_REJECT;
            end
            escape_seen_next = 1'b0;
          end else if (last_byte == MARK_BYTE && !escape_seen) begin
            if (data_byte == MARK_BYTE) begin
              frame_pending_next = 1'b1;
              escape_seen_next   = 1'b0;
              ev_next            = EV_COMPLETE;
            end else if (data_byte == STUFF_BYTE) begin
              byte_count_next  = byte_count;
              last_byte_next   = last_byte;
              escape_seen_next = 1'b1;
              ev_next          = EV_ESCAPE_DROPPED;
            end else if (data_byte == HEAD_BYTE) begin
              byte_count_next  = '0;
              escape_seen_next = 1'b0;
              ev_next          = EV_RESTART;
            end
          end else begin
            escape_seen_next = 1'b0;
          end
          // store full before the frame closed
          if (32'(byte_count_next) >= 32'(STORE_DEPTH) && !frame_pending_next) begin
            byte_count_next = '0;
            ev_next         = EV_OVERFLOW;
          end
        end
      end
      OP_READ: begin
        ev_next = EV_DONE;
      end
      OP_RELEASE: begin
        byte_count_next    = '0;
        frame_pending_next = 1'b0;
      end
      default: begin
        ev_next = EV_DONE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      frame_pending <= 1'b0;
      escape_seen   <= 1'b0;
      last_byte     <= '0;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      frame_pending <= frame_pending_next;
      escape_seen   <= escape_seen_next;
      last_byte     <= last_byte_next;
    end
  end

  // Frame store
  efr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(byte_count[STORE_AW-1:0]),
    .wdata(data_byte),
    .re   (store_re),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_q         <= ev_next;
      frame_length <= 9'(byte_count_next);
      frame_ready  <= frame_pending_next;
      rd_sel       <= store_re;
    end
  end

  assign event_res = ev_q;
  assign read_data = rd_sel ? ram_q : 8'h00;

endmodule

@@ sv/efr_ram.sv @@
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/efr_checker.sv @@
module efr_checker
  import efr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] event_res,
  input logic [8:0] frame_length,
  input logic       frame_ready,
  input logic [7:0] read_data
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_res)
      && $stable(frame_length) && $stable(frame_ready) && $stable(read_data))
    else $error("result beat changed while stalled");

  // a refused push or a completed frame leaves a frame pending
  a_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_REFUSED || event_res == EV_COMPLETE) |-> frame_ready)
    else $error("pending flag low on refuse or complete");

  // only reads return data
  a_rdata: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_DONE |-> read_data == 8'h00)
    else $error("read data on non-read beat");

  // reject, restart and overflow empty the store count
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_HEADER_REJECT || event_res == EV_RESTART
      || event_res == EV_OVERFLOW) |-> frame_length == 9'd0 && !frame_ready)
    else $error("count not cleared");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .event_res   (event_res),
  .frame_length(frame_length),
  .frame_ready (frame_ready),
  .read_data   (read_data)
);
